// ===== rtl/assert_macros.svh =====
// Assertion macros used by the keypad checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked assertion, also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/kpd_pkg.sv =====
// Types and constants of the keypad scanner.
package kpd_pkg;

    localparam int ROWS    = 4;
    localparam int COLUMNS = 3;
    localparam int ROW_W   = 2;
    localparam int KEY_W   = $clog2(ROWS * COLUMNS);
    localparam int CODE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODES_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODES_LAST  = 2'd2;

    localparam logic [CNT_W-1:0] RESET_DEBOUNCE    = 8'd5;
    localparam logic [CFG_W-1:0] RESET_CODES_FIRST = 48'd59602136937009;
    localparam logic [CFG_W-1:0] RESET_CODES_LAST  = 48'd38689773795383;

    typedef struct packed {
        logic [COLUMNS-1:0][CNT_W-1:0] cnt;
        logic [COLUMNS-1:0]            stable;
        logic [COLUMNS-1:0]            last;
    } row_state_t;

    localparam row_state_t RESET_ROW = '{
        cnt:    {COLUMNS{RESET_DEBOUNCE}},
        stable: '0,
        last:   '0
    };

    typedef struct packed {
        logic                           scan;
        logic                           pop;
        logic [COLUMNS-1:0]             press;
        logic [COLUMNS-1:0][CODE_W-1:0] codes;
    } queue_req_t;

    typedef struct packed {
        logic valid;
        logic empty;
        logic dropped;
    } queue_stat_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_row;
        logic             valid;
        logic             empty;
        logic             dropped;
    } stage_t;

endpackage

// ===== rtl/kpd_row_store.sv =====
// Row state memory with per-row valid bits and write-to-read forwarding.
module kpd_row_store
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [kpd_pkg::ROW_W-1:0]         waddr,
    input  kpd_pkg::row_state_t               wdata,
    input  logic [kpd_pkg::ROW_W-1:0]         raddr,
    output kpd_pkg::row_state_t               rdata
);

    kpd_pkg::row_state_t             row_mem [kpd_pkg::ROWS];
    logic [kpd_pkg::ROWS-1:0]        valid_reg;
    kpd_pkg::row_state_t             rdata_reg;
    logic                            rvalid_reg;
    logic                            hit;

    assign hit = we && (waddr == raddr);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
        rdata_reg <= hit ? wdata : row_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= hit || valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : kpd_pkg::RESET_ROW;

endmodule

// ===== rtl/kpd_debounce.sv =====
// Debounce update of one row of keys and key code lookup.
module kpd_debounce
(
    input  logic [kpd_pkg::COLUMNS-1:0]                      levels,
    input  logic [kpd_pkg::ROW_W-1:0]                        row,
    input  kpd_pkg::row_state_t                              cur,
    input  logic [kpd_pkg::CNT_W-1:0]                        debounce_ticks,
    input  logic [kpd_pkg::CFG_W-1:0]                        codes_first,
    input  logic [kpd_pkg::CFG_W-1:0]                        codes_last,
    output kpd_pkg::row_state_t                              nxt,
    output logic [kpd_pkg::COLUMNS-1:0]                      press,
    output logic [kpd_pkg::COLUMNS-1:0][kpd_pkg::CODE_W-1:0] codes
);

    logic [2*kpd_pkg::CFG_W-1:0] code_table;

    assign code_table = {codes_last, codes_first};

    always_comb
    begin
        logic                      rd;
        logic [kpd_pkg::KEY_W-1:0] key_idx;
        nxt   = cur;
        press = '0;
        for (int c = 0; c < kpd_pkg::COLUMNS; c++)
        begin
            rd      = levels[c];
            key_idx = kpd_pkg::KEY_W'(int'(row) * kpd_pkg::COLUMNS + c);
            codes[c] = code_table[{key_idx, 3'b000} +: kpd_pkg::CODE_W];
            if (rd == cur.last[c])
            begin
                if (cur.cnt[c] != '0)
                begin
                    nxt.cnt[c] = cur.cnt[c] - 8'd1;
                    if ((nxt.cnt[c] == '0) && (rd != cur.stable[c]))
                    begin
                        nxt.stable[c] = rd;
                        press[c]      = !rd;
                    end
                end
            end
            else
            begin
                nxt.last[c] = rd;
                nxt.cnt[c]  = debounce_ticks;
            end
        end
    end

endmodule

// ===== rtl/kpd_key_queue.sv =====
// Key code queue in one bank memory per column, up to one push per bank a cycle.
module kpd_key_queue #(
    parameter int QUEUE_KEYS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  kpd_pkg::queue_req_t         req,
    output kpd_pkg::queue_stat_t        stat,
    output logic [kpd_pkg::CODE_W-1:0]  pop_code
);

    localparam int BANKS = kpd_pkg::COLUMNS;
    localparam int DEPTH = (QUEUE_KEYS + BANKS - 1) / BANKS;
    localparam int RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = $clog2(BANKS);
    localparam int CW    = $clog2(QUEUE_KEYS + 1);
    localparam int NW    = $clog2(BANKS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [BW-1:0] wr_bank_reg, wr_bank_next;
    logic [RW-1:0] wr_row_reg, wr_row_next;
    logic [BW-1:0] rd_bank_reg, rd_bank_next;
    logic [RW-1:0] rd_row_reg, rd_row_next;
    logic [BW-1:0] rd_sel_reg;
    logic [kpd_pkg::CODE_W-1:0] rdata_reg [BANKS];

    logic [NW-1:0] n_push;
    logic [kpd_pkg::CODE_W-1:0] push_code [BANKS];
    logic [CW-1:0] avail;
    logic          dropped;
    logic          pop_ok;

    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
        return (r == RW'(DEPTH - 1)) ? '0 : r + RW'(1);
    endfunction

    always_comb
    begin
        avail   = count_reg;
        n_push  = '0;
        dropped = 1'b0;
        for (int j = 0; j < BANKS; j++)
        begin
            push_code[j] = '0;
        end
        for (int c = 0; c < BANKS; c++)
        begin
            if (req.scan && req.press[c])
            begin
                if (avail < CW'(QUEUE_KEYS))
                begin
                    push_code[n_push[BW-1:0]] = req.codes[c];
                    n_push = n_push + NW'(1);
                    avail  = avail + CW'(1);
                end
                else
                begin
                    dropped = 1'b1;
                end
            end
        end
    end

    assign pop_ok = req.pop && (count_reg != '0);

    always_comb
    begin
        logic [BW:0] sum;
        sum          = {1'b0, wr_bank_reg} + (BW+1)'(n_push);
        wr_bank_next = wr_bank_reg;
        wr_row_next  = wr_row_reg;
        rd_bank_next = rd_bank_reg;
        rd_row_next  = rd_row_reg;
        count_next   = avail;
        if (sum >= (BW+1)'(BANKS))
        begin
            wr_bank_next = BW'(sum - (BW+1)'(BANKS));
            wr_row_next  = row_inc(wr_row_reg);
        end
        else
        begin
            wr_bank_next = sum[BW-1:0];
        end
        if (pop_ok)
        begin
            count_next = count_reg - CW'(1);
            if (rd_bank_reg == BW'(BANKS - 1))
            begin
                rd_bank_next = '0;
                rd_row_next  = row_inc(rd_row_reg);
            end
            else
            begin
                rd_bank_next = rd_bank_reg + BW'(1);
            end
        end
    end

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [kpd_pkg::CODE_W-1:0] bank_mem [DEPTH];
        logic [BW:0]                off_raw;
        logic [BW-1:0]              off;
        logic                       we;
        logic [RW-1:0]              waddr;

        always_comb
        begin
            off_raw = (BW+1)'(b + BANKS) - (BW+1)'(wr_bank_reg);
            off     = (off_raw >= (BW+1)'(BANKS)) ? BW'(off_raw - (BW+1)'(BANKS))
                                                  : off_raw[BW-1:0];
            we      = (NW'(off) < n_push);
            waddr   = (BW'(b) < wr_bank_reg) ? row_inc(wr_row_reg) : wr_row_reg;
        end

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                bank_mem[waddr] <= push_code[off];
            end
            if (req.pop)
            begin
                rdata_reg[b] <= bank_mem[rd_row_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.pop)
        begin
            rd_sel_reg <= rd_bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            wr_bank_reg <= '0;
            wr_row_reg  <= '0;
            rd_bank_reg <= '0;
            rd_row_reg  <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            wr_bank_reg <= wr_bank_next;
            wr_row_reg  <= wr_row_next;
            rd_bank_reg <= rd_bank_next;
            rd_row_reg  <= rd_row_next;
        end
    end

    assign stat.valid   = pop_ok;
    assign stat.empty   = (count_next == '0);
    assign stat.dropped = dropped;
    assign pop_code     = rdata_reg[rd_sel_reg];

endmodule

// ===== rtl/matrix_keypad_scanner_unit.sv =====
// Top level of the 4x3 keypad scanner with per-key debounce and key queue.
//
// Input stream: s_tuser[0] is the request kind (0 scan tick, 1 pop), s_tdata[2:0]
// carries the column levels sampled while next_row is driven low.
// Output stream: one result per input request, in request order, in m_tdata.
// Config channel: cfg_index 0 debounce ticks, 1 codes of rows 0-1, 2 codes of
// rows 2-3; cfg_ready is always high; the user must write only while the block
// idles, which the block itself does not enforce. Throughput: one request per
// cycle while the output is not stalled. The row state memory read is registered
// (prefetched at the next row address), as are the key queue bank reads on a pop.
// The queue is split into three bank memories so that a scan that validates
// presses on all three columns writes all of them in the same cycle.
// Reset: row 0 next, queue empty, all keys held pressed with counters at 5,
// debounce 5 and default key codes; row valid bits stand in for the row memory
// contents, so no clearing pass runs and requests are taken right away.
// Stall: a result waits in the output register while m_tready is low; one more
// request is taken into the middle stage, then s_tready drops until the
// output register drains.
module matrix_keypad_scanner_unit #(
    parameter int QUEUE_KEYS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [2:0] column_levels
    input  logic [0:0]                        s_tuser,   // [0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [1:0] next_row, [9:2] key_code,
                                                         // [10] key_valid, [11] queue_empty,
                                                         // [12] key_dropped
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kpd_pkg::CFG_W-1:0]         cfg_data
);

    logic [kpd_pkg::CNT_W-1:0]  debounce_reg;
    logic [kpd_pkg::CFG_W-1:0]  codes_first_reg;
    logic [kpd_pkg::CFG_W-1:0]  codes_last_reg;
    logic [kpd_pkg::ROW_W-1:0]  scan_row_reg, scan_row_next;
    logic                       p1_valid_reg, p1_valid_next;
    kpd_pkg::stage_t            p1_reg, p1_next;
    logic                       out_valid_reg, out_valid_next;
    logic [15:0]                out_data_reg;

    logic                       accept;
    logic                       p1_adv;
    kpd_pkg::row_state_t        row_cur;
    kpd_pkg::row_state_t        row_new;
    logic [kpd_pkg::COLUMNS-1:0] press;
    logic [kpd_pkg::COLUMNS-1:0][kpd_pkg::CODE_W-1:0] codes;
    kpd_pkg::queue_req_t        qreq;
    kpd_pkg::queue_stat_t       qstat;
    logic [kpd_pkg::CODE_W-1:0] pop_code;

    assign cfg_ready = 1'b1;
    assign p1_adv    = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !p1_valid_reg || p1_adv;
    assign accept    = s_tvalid && s_tready;

    assign qreq.scan  = accept && (s_tuser[0] == kpd_pkg::CMD_SCAN);
    assign qreq.pop   = accept && (s_tuser[0] == kpd_pkg::CMD_POP);
    assign qreq.press = press;
    assign qreq.codes = codes;

    always_comb
    begin
        scan_row_next = scan_row_reg;
        if (qreq.scan)
        begin
            scan_row_next = (scan_row_reg == kpd_pkg::ROW_W'(kpd_pkg::ROWS - 1))
                          ? '0 : scan_row_reg + kpd_pkg::ROW_W'(1);
        end
    end

    kpd_row_store u_row_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (qreq.scan),
        .waddr (scan_row_reg),
        .wdata (row_new),
        .raddr (scan_row_next),
        .rdata (row_cur)
    );

    kpd_debounce u_debounce
    (
        .levels         (s_tdata[kpd_pkg::COLUMNS-1:0]),
        .row            (scan_row_reg),
        .cur            (row_cur),
        .debounce_ticks (debounce_reg),
        .codes_first    (codes_first_reg),
        .codes_last     (codes_last_reg),
        .nxt            (row_new),
        .press          (press),
        .codes          (codes)
    );

    kpd_key_queue #(
        .QUEUE_KEYS (QUEUE_KEYS)
    ) u_key_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (qreq),
        .stat     (qstat),
        .pop_code (pop_code)
    );

    always_comb
    begin
        p1_next          = p1_reg;
        p1_valid_next    = p1_valid_reg;
        if (accept)
        begin
            p1_next.next_row = scan_row_next;
            p1_next.valid    = qstat.valid;
            p1_next.empty    = qstat.empty;
            p1_next.dropped  = qstat.dropped;
            p1_valid_next    = 1'b1;
        end
        else if (p1_adv)
        begin
            p1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (p1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;
        if (p1_adv)
        begin
            out_data_reg <= {3'b000, p1_reg.dropped, p1_reg.empty, p1_reg.valid,
                             p1_reg.valid ? pop_code : kpd_pkg::CODE_W'(0),
                             p1_reg.next_row};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg    <= '0;
            p1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            debounce_reg    <= kpd_pkg::RESET_DEBOUNCE;
            codes_first_reg <= kpd_pkg::RESET_CODES_FIRST;
            codes_last_reg  <= kpd_pkg::RESET_CODES_LAST;
        end
        else
        begin
            scan_row_reg  <= scan_row_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    kpd_pkg::CFG_DEBOUNCE:    debounce_reg    <= cfg_data[kpd_pkg::CNT_W-1:0];
                    kpd_pkg::CFG_CODES_FIRST: codes_first_reg <= cfg_data;
                    kpd_pkg::CFG_CODES_LAST:  codes_last_reg  <= cfg_data;
                    default:                  ;
                endcase
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/kpd_checker.sv =====
// Port-level checker of the keypad scanner and its bind.
`include "assert_macros.svh"

module kpd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `ASSERT_CLK(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `ASSERT_CLK(a_result_due, clk, rst_n, s_tvalid && s_tready |-> ##2 m_tvalid)
    `ASSERT_CLK(a_pop_no_drop, clk, rst_n, m_tvalid |-> !(m_tdata[10] && m_tdata[12]))
    `ASSERT_CLK_ALWAYS(a_reset_idle, clk, !rst_n |=> !m_tvalid)

endmodule

bind matrix_keypad_scanner_unit kpd_checker u_kpd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
